FILE: rtl/lsgr_pkg.sv
// shared types and constants for the lpcm sample group repacker
`default_nettype none
package lsgr_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned GROUP20_LEN = 10;
   localparam int unsigned GROUP24_LEN = 12;
   localparam int unsigned STORE_DEPTH = 12;
   localparam int unsigned POS_W       = $clog2(STORE_DEPTH + 1);
   localparam int unsigned CNT_W       = $clog2(STORE_DEPTH + 1);

   localparam logic [BYTE_W-1:0] HI_NIBBLE = 8'hf0;
   localparam logic [BYTE_W-1:0] LO_NIBBLE = 8'h0f;

   typedef enum logic [1:0] {
      MODE_16 = 2'd0,
      MODE_20 = 2'd1,
      MODE_24 = 2'd2
   } mode_type;

   typedef logic [BYTE_W-1:0] byte_type;

   // one load into the output buffer: a whole group or a single byte
   typedef struct packed {
      logic                          load;
      logic                          single;
      logic [STORE_DEPTH-1:0][BYTE_W-1:0] bytes;
   } load_type;

endpackage
`default_nettype wire

FILE: rtl/lsgr_collector.sv
// input register file, group position and sample group reordering
`default_nettype none
module lsgr_collector (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   input  wire logic [1:0]             csr_data,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [7:0]             req_tdata,
   input  wire logic                   req_tlast,
   input  wire logic                   can_load,
   output lsgr_pkg::load_type          load_out,
   output lsgr_pkg::mode_type          mode_out
);
   import lsgr_pkg::*;

   mode_type                      mode_ff, mode_in;
   logic [POS_W-1:0]              pos_ff, pos_in;
   byte_type                      store_ff [STORE_DEPTH];
   byte_type                      s [STORE_DEPTH];
   logic                          grouped;
   logic                          completes;
   logic                          accept;
   logic [POS_W-1:0]              last_pos;

   always_comb begin
      grouped  = 1'b0;
      last_pos = POS_W'(GROUP20_LEN - 1);
      case (mode_ff)
         MODE_20: begin
            grouped  = 1'b1;
            last_pos = POS_W'(GROUP20_LEN - 1);
         end
         MODE_24: begin
            grouped  = 1'b1;
            last_pos = POS_W'(GROUP24_LEN - 1);
         end
         default: begin
            grouped  = 1'b0;
            last_pos = POS_W'(GROUP20_LEN - 1);
         end
      endcase
   end

   assign completes = grouped && (pos_ff == last_pos);

   always_comb begin
      case (mode_ff)
         MODE_16:          req_tready = can_load;
         MODE_20, MODE_24: req_tready = !completes || can_load;
         default:          req_tready = 1'b1;
      endcase
   end

   assign accept = req_tvalid && req_tready;

   // group view with the incoming byte in its final place
   always_comb begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
         s[i] = store_ff[i];
      end
      if (mode_ff == MODE_20) begin
         s[GROUP20_LEN-1] = req_tdata;
      end else begin
         s[GROUP24_LEN-1] = req_tdata;
      end
   end

   always_comb begin
      load_out.load   = accept && ((mode_ff == MODE_16) || completes);
      load_out.single = (mode_ff == MODE_16);
      load_out.bytes  = '0;
      case (mode_ff)
         MODE_16: begin
            load_out.bytes[0] = req_tdata;
         end
         MODE_20: begin
            load_out.bytes[0]  = s[0];
            load_out.bytes[1]  = s[1];
            load_out.bytes[2]  = s[8] & HI_NIBBLE;
            load_out.bytes[3]  = s[2];
            load_out.bytes[4]  = s[3];
            load_out.bytes[5]  = (s[8] & LO_NIBBLE) << 4;
            load_out.bytes[6]  = s[4];
            load_out.bytes[7]  = s[5];
            load_out.bytes[8]  = s[9] & HI_NIBBLE;
            load_out.bytes[9]  = s[6];
            load_out.bytes[10] = s[7];
            load_out.bytes[11] = (s[9] & LO_NIBBLE) << 4;
         end
         default: begin
            load_out.bytes[0]  = s[0];
            load_out.bytes[1]  = s[1];
            load_out.bytes[2]  = s[8];
            load_out.bytes[3]  = s[2];
            load_out.bytes[4]  = s[3];
            load_out.bytes[5]  = s[9];
            load_out.bytes[6]  = s[4];
            load_out.bytes[7]  = s[5];
            load_out.bytes[8]  = s[10];
            load_out.bytes[9]  = s[6];
            load_out.bytes[10] = s[7];
            load_out.bytes[11] = s[11];
         end
      endcase
   end

   always_comb begin
      mode_in = mode_ff;
      pos_in  = pos_ff;
      if (csr_valid) begin
         mode_in = mode_type'(csr_data);
         pos_in  = '0;
      end else if (accept) begin
         if (!grouped || completes || req_tlast) begin
            pos_in = '0;
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_16;
         pos_ff  <= '0;
      end else begin
         mode_ff <= mode_in;
         pos_ff  <= pos_in;
      end
   end

   // group store, no reset
   always_ff @(posedge clock) begin
      if (accept && grouped) begin
         store_ff[pos_ff] <= req_tdata;
      end
   end

   assign mode_out = mode_ff;

endmodule
`default_nettype wire

FILE: rtl/lsgr_emitter.sv
// output byte buffer that shifts out one byte per transfer
`default_nettype none
module lsgr_emitter (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire lsgr_pkg::load_type     load_in,
   output logic                        can_load,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [7:0]                  rsp_tdata,
   output logic                        rsp_tlast
);
   import lsgr_pkg::*;

   byte_type            buf_ff [STORE_DEPTH];
   byte_type            buf_in [STORE_DEPTH];
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                take;

   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_tlast  = (cnt_ff == CNT_W'(1));
   assign rsp_tdata  = buf_ff[0];
   assign take       = rsp_tvalid && rsp_tready;
   assign can_load   = (cnt_ff == '0) || (rsp_tlast && rsp_tready);

   always_comb begin
      cnt_in = cnt_ff;
      for (int i = 0; i < STORE_DEPTH; i++) begin
         buf_in[i] = buf_ff[i];
      end
      if (load_in.load) begin
         for (int i = 0; i < STORE_DEPTH; i++) begin
            buf_in[i] = load_in.bytes[i];
         end
         cnt_in = load_in.single ? CNT_W'(1) : CNT_W'(STORE_DEPTH);
      end else if (take) begin
         for (int i = 0; i < STORE_DEPTH - 1; i++) begin
            buf_in[i] = buf_ff[i+1];
         end
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
         buf_ff[i] <= buf_in[i];
      end
   end

endmodule
`default_nettype wire

FILE: rtl/lpcm_sample_group_repacker.sv
// top level of the lpcm sample group repacker
//
// channel  direction  handshake                 payload
// req      in         req_tvalid / req_tready   tdata data_byte, tlast frame_end
// rsp      out        rsp_tvalid / rsp_tready   tdata out_byte, tlast run_last
// csr      in         csr_valid / csr_ready     csr_data sample_width_mode
//
// one input byte per cycle is taken while no load waits on the buffer; a finished group
// loads a 12 byte buffer in the same cycle and the buffer gives one byte per transfer
// the completing byte of a group waits until the buffer is empty or its last byte is taken
// 16-bit mode passes one byte per cycle through the same buffer while the output accepts
// reset clears the mode to 16-bit, the group position and the buffer count
`default_nettype none
module lpcm_sample_group_repacker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tlast,   // frame_end
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] out_byte
   output logic             rsp_tlast,   // run_last
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_data     // [1:0] sample_width_mode
);
   import lsgr_pkg::*;

   load_type  load_ev;
   mode_type  mode;
   logic      can_load;

   assign csr_ready = 1'b1;

   lsgr_collector u_collector (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid && csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .can_load   (can_load),
      .load_out   (load_ev),
      .mode_out   (mode)
   );

   lsgr_emitter u_emitter (
      .clock      (clock),
      .reset      (reset),
      .load_in    (load_ev),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load_ev.load |=> rsp_tvalid)
      else $error("loaded buffer not presented");

   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with empty buffer");

   a_unused_mode: assert property (@(posedge clock) disable iff (reset)
      (mode != MODE_16 && mode != MODE_20 && mode != MODE_24) |-> !load_ev.load)
      else $error("unused mode produced output");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load_ev.load |-> can_load)
      else $error("buffer overwritten");

endmodule
`default_nettype wire

FILE: bench/tb_lpcm_sample_group_repacker.sv
// self-checking testbench for the lpcm sample group repacker
`default_nettype none
module tb_lpcm_sample_group_repacker;
   import lsgr_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned RSP_HOLD = 300;
   localparam int unsigned SETTLE_CYCLES = 8;

   typedef enum logic [1:0] {
      ROW_CSR,
      ROW_PREDICT,
      ROW_PASS,
      ROW_DROP
   } row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [7:0]   value;
      logic         fend;
   } stim_row_type;

   typedef struct packed {
      byte_type pcm;
      logic     last;
   } pcm_out_type;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] data_byte
   logic       req_tlast = 1'b0;    // frame_end
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] out_byte
   logic       rsp_tlast;           // run_last
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_data = 2'd0;     // [1:0] sample_width_mode

   pcm_out_type pcm_expect [$];
   pcm_out_type pcm_want;
   byte_type    grp [STORE_DEPTH];
   int unsigned grp_pos = 0;
   logic [1:0]  width_mode = MODE_16;
   int unsigned fail_count = 0;
   int unsigned cycle_count = 0;
   bit          calm = 1'b0;
   bit          hold_rsp = 1'b0;

   // groups: a 16-bit byte, 20-bit with nibble-rich trailing bytes, a one-byte broken frame,
   // 24-bit completed by the frame end byte, and the unused mode
   stim_row_type directed_rows [0:28] = '{
      '{ROW_PASS,    8'h5a, 1'b1},
      '{ROW_CSR,     8'(MODE_20), 1'b0},
      '{ROW_PREDICT, 8'h00, 1'b0},
      '{ROW_PREDICT, 8'hff, 1'b0},
      '{ROW_PREDICT, 8'h12, 1'b0},
      '{ROW_PREDICT, 8'h34, 1'b0},
      '{ROW_PREDICT, 8'h56, 1'b0},
      '{ROW_PREDICT, 8'h78, 1'b0},
      '{ROW_PREDICT, 8'h9a, 1'b0},
      '{ROW_PREDICT, 8'hbc, 1'b0},
      '{ROW_PREDICT, 8'ha5, 1'b0},
      '{ROW_PREDICT, 8'h3c, 1'b0},
      '{ROW_PREDICT, 8'h77, 1'b1},
      '{ROW_CSR,     8'(MODE_24), 1'b0},
      '{ROW_PREDICT, 8'h80, 1'b0},
      '{ROW_PREDICT, 8'h7f, 1'b0},
      '{ROW_PREDICT, 8'h01, 1'b0},
      '{ROW_PREDICT, 8'hfe, 1'b0},
      '{ROW_PREDICT, 8'h11, 1'b0},
      '{ROW_PREDICT, 8'h22, 1'b0},
      '{ROW_PREDICT, 8'h33, 1'b0},
      '{ROW_PREDICT, 8'h44, 1'b0},
      '{ROW_PREDICT, 8'hc8, 1'b0},
      '{ROW_PREDICT, 8'hd9, 1'b0},
      '{ROW_PREDICT, 8'hea, 1'b0},
      '{ROW_PREDICT, 8'hfb, 1'b1},
      '{ROW_CSR,     8'(MODE_UNUSED), 1'b0},
      '{ROW_DROP,    8'hc3, 1'b0},
      '{ROW_DROP,    8'h3c, 1'b1}
   };

   logic [1:0] phase_modes [0:7] = '{
      MODE_20, MODE_24, MODE_16, MODE_20, MODE_20, MODE_UNUSED, MODE_24, MODE_16
   };

   lpcm_sample_group_repacker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // group bytes, emit big-endian samples once whole; 16-bit bytes pass, unused mode drops
   function automatic void repack_byte(input byte_type din, input logic fend, input bit keep);
      int unsigned need;
      byte_type    pcm [12];
      byte_type    extra;
      if (width_mode == MODE_16) begin
         grp_pos = 0;
         if (keep) pcm_expect.push_back('{pcm: din, last: 1'b1});
         return;
      end
      if (width_mode == MODE_UNUSED) begin
         grp_pos = 0;
         return;
      end
      need = (width_mode == MODE_20) ? GROUP20_LEN : GROUP24_LEN;
      grp[grp_pos] = din;
      grp_pos++;
      if (grp_pos < need) begin
         if (fend) grp_pos = 0;
         return;
      end
      grp_pos = 0;
      for (int k = 0; k < 4; k++) begin
         pcm[3*k]   = grp[2*k];
         pcm[3*k+1] = grp[2*k+1];
         extra = grp[8 + ((width_mode == MODE_20) ? k / 2 : k)];
         if (width_mode == MODE_24) begin
            pcm[3*k+2] = extra;
         end else if (k % 2 == 0) begin
            pcm[3*k+2] = extra & HI_NIBBLE;
         end else begin
            pcm[3*k+2] = byte_type'((extra & LO_NIBBLE) << 4);
         end
      end
      if (keep) begin
         for (int k = 0; k < 12; k++) pcm_expect.push_back('{pcm: pcm[k], last: 1'(k == 11)});
      end
   endfunction

   task automatic send_byte(input byte_type d, input logic f, input row_kind_type kind);
      while (!calm && $urandom_range(0, 99) < 35) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tlast  <= f;
      do @(posedge clock); while (!req_tready);
      repack_byte(d, f, kind == ROW_PREDICT);
      if (kind == ROW_PASS) pcm_expect.push_back('{pcm: d, last: 1'b1});
   endtask

   // stop offering and let every expected transfer drain
   task automatic quiet_wait();
      req_tvalid <= 1'b0;
      while (pcm_expect.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic [1:0] m);
      quiet_wait();
      csr_valid <= 1'b1;
      csr_data  <= m;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      width_mode = m;
      grp_pos    = 0;
   endtask

   initial begin : rsp_side
      int unsigned held;
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_tready <= 1'b0;
            for (held = 0; held < RSP_HOLD; held++) @(posedge clock);
         end else begin
            rsp_tready <= calm || ($urandom_range(0, 99) >= 35);
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pcm_expect.size() == 0) begin
            $error("unexpected transfer: out_byte %h run_last %b", rsp_tdata, rsp_tlast);
            fail_count++;
         end else begin
            pcm_want = pcm_expect.pop_front();
            if (rsp_tdata !== pcm_want.pcm) begin
               $error("out_byte: expected %h, actual %h", pcm_want.pcm, rsp_tdata);
               fail_count++;
            end
            if (rsp_tlast !== pcm_want.last) begin
               $error("run_last: expected %b, actual %b", pcm_want.last, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   initial begin : stimulus
      int unsigned need;
      int unsigned budget;
      int unsigned sent;
      int unsigned flen;
      int unsigned shape;
      bit          paused;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            write_mode(directed_rows[i].value[1:0]);
         end else begin
            send_byte(directed_rows[i].value, directed_rows[i].fend, directed_rows[i].kind);
         end
      end

      for (int p = 0; p < 8; p++) begin
         write_mode(phase_modes[p]);
         case (phase_modes[p])
            MODE_20: need = GROUP20_LEN;
            MODE_24: need = GROUP24_LEN;
            default: need = 1;
         endcase
         budget = (phase_modes[p] == MODE_UNUSED) ? 8 : 20;
         calm   = (p == 1);
         if (p == 2) hold_rsp = 1'b1;
         sent   = 0;
         paused = 1'b0;
         while (sent < budget) begin
            // mostly whole groups closed by a frame end, some broken or unterminated
            flen  = need * $urandom_range(1, 3);
            shape = $urandom_range(0, 9);
            if (shape < 2 && need > 1) begin
               flen = flen - $urandom_range(1, need - 1);
            end else if (shape == 2) begin
               flen = $urandom_range(1, 30);
            end
            for (int i = 0; i < flen; i++) begin
               send_byte(byte_type'($urandom_range(0, 255)), (i == flen - 1) && (shape != 9),
                         ROW_PREDICT);
               sent++;
            end
            if (p == 3 && !paused && sent >= budget / 2) begin
               paused = 1'b1;
               quiet_wait();
            end
         end
         calm = 1'b0;
      end

      quiet_wait();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
`default_nettype wire
